// ===== hw/rtl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// shared types and constants of the ntc thermistor to celsius converter
// ----------------------------------------------------------------------------
package ntc_pkg;

	// default adc width
	localparam int ADC_BITS_DEF = 12;

	// configuration register widths
	localparam int FS_W   = 13;
	localparam int RES_W  = 20;
	localparam int BETA_W = 14;
	localparam int TNOM_W = 16;

	// configuration reset values
	localparam logic [FS_W-1:0]   FS_RST   = 13'd4095;
	localparam logic [RES_W-1:0]  RREF_RST = 20'd10000;
	localparam logic [RES_W-1:0]  RNOM_RST = 20'd10000;
	localparam logic [BETA_W-1:0] BETA_RST = 14'd3950;
	localparam logic [TNOM_W-1:0] TNOM_RST = 16'd29815;

	// fixed point
	localparam int LOG_FRAC  = 48;
	localparam int LOG_W     = 54;
	localparam int LN_W      = 47;
	localparam int LOG_LAT   = 1 + 2 * LOG_FRAC;
	localparam int Q_BITS    = 17;
	localparam int DEN_W     = 64;
	localparam int NUMER_W   = 77;
	localparam int REM_W     = DEN_W + Q_BITS + 1;
	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;

	localparam int TEMP_W = 18;
	localparam logic [17:0] KELVIN_CENTI = 18'd27315;
	localparam logic [17:0] TEMP_MAX     = 18'd100000;
	localparam logic [17:0] Q_MAX        = 18'd127315;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FAULT = 2'd1,
		ST_SAT   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_FULL_SCALE = 3'd0,
		REG_RREF       = 3'd1,
		REG_RNOM       = 3'd2,
		REG_BETA       = 3'd3,
		REG_TNOM       = 3'd4
	} cfg_reg_t;

	// control that travels with each beat
	typedef struct packed {
		logic valid;
		logic fault;
		logic sat;
	} ntc_tag_t;

endpackage

// ===== hw/rtl/ntc_thermistor_to_celsius.sv =====
// ----------------------------------------------------------------------------
// ntc_thermistor_to_celsius
// ntc divider adc count to temperature in 0.01 degC by the beta equation
// ----------------------------------------------------------------------------
// Fully pipelined: one adc count may be started every clock cycle (busy stays
// low) and each result appears with a one-cycle result_valid strobe, in order.
// Most of the pipeline lies in the two log2 pipelines (48 squaring steps,
// each a split 63x63 multiply over two stages) and the 17-stage restoring
// divider. Results cannot be held off, so the receiver must take every
// strobe. status 0 is ok, 1 a sensor fault (count zero, count at or above
// full scale, or a zero register) with temperature 0, and 2 saturation at
// 100000. Registers must be written by the user through the cfg port only
// while no conversion is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module ntc_thermistor_to_celsius #(
	parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	output logic                 busy,
	input  logic [ADC_BITS-1:0]  adc_code,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [19:0]          cfg_data,
	// results
	output logic                 result_valid,
	output logic signed [17:0]   temperature_centi_c,
	output logic [1:0]           status
);
	import ntc_pkg::*;

	localparam int CW    = (ADC_BITS > FS_W) ? ADC_BITS : FS_W;
	localparam int NUM_W = RES_W + ADC_BITS;
	localparam int DNM_W = RES_W + FS_W;
	localparam int VW    = (NUM_W > DNM_W) ? NUM_W : DNM_W;

	// configuration registers
	logic [FS_W-1:0]   fs_q;
	logic [RES_W-1:0]  rref_q;
	logic [RES_W-1:0]  rnom_q;
	logic [BETA_W-1:0] beta_q;
	logic [TNOM_W-1:0] tnom_q;
	logic [36:0]       p_q;     // 100 * tnom * beta
	logic [60:0]       base_q;  // 100 * beta in q40

	// front end
	ntc_tag_t           tag_s1, tag_s2;
	logic [ADC_BITS-1:0] adc_s1;
	logic [VW-1:0]      num_s2, den_s2;
	logic               fault;
	logic [CW-1:0]      span;

	// log stage delay line for control
	ntc_tag_t tag_d [0:LOG_LAT-1];
	logic [LOG_W-1:0] lnum, lden;

	// back end
	ntc_tag_t tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic             neg_s3, neg_s4, neg_s5, neg_s6;
	logic [LOG_W-1:0] mag_s3;
	logic [63:0]      b0c0_s4, b0c1_s4;
	logic [53:0]      b1c0_s4, b1c1_s4;
	logic [LN_W-1:0]  ln_s5;
	logic [62:0]      prod_s6;
	logic [DEN_W-1:0] d_s7;
	logic [NUMER_W-1:0] n_s7;

	logic [LOG_W:0]   diff;
	logic [117:0]     lsum;
	logic [LOG_W:0]   lnr;
	logic [65:0]      dq;
	status_t          st;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= FS_RST;
			rref_q <= RREF_RST;
			rnom_q <= RNOM_RST;
			beta_q <= BETA_RST;
			tnom_q <= TNOM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FULL_SCALE: fs_q   <= cfg_data[FS_W-1:0];
				REG_RREF:       rref_q <= cfg_data[RES_W-1:0];
				REG_RNOM:       rnom_q <= cfg_data[RES_W-1:0];
				REG_BETA:       beta_q <= cfg_data[BETA_W-1:0];
				REG_TNOM:       tnom_q <= cfg_data[TNOM_W-1:0];
				default:        ;
			endcase
		end
	end

	// derived constants, stable long before any beat needs them
	always_ff @(posedge clk) begin
		p_q    <= 37'(37'(tnom_q) * 37'(beta_q)) * 37'd100;
		base_q <= 61'(21'(beta_q) * 21'd100) << 40;
	end

	// ---------------- stage 1: capture and fault check ----------------
	assign fault = (adc_code == '0) || (CW'(adc_code) >= CW'(fs_q)) ||
	               (rref_q == '0) || (rnom_q == '0) || (beta_q == '0) ||
	               (tnom_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= '{valid: start && !busy, fault: fault, sat: 1'b0};
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		adc_s1 <= adc_code;
	end

	// ---------------- stage 2: divider numerator and denominator ----------------
	assign span = CW'(fs_q) - CW'(adc_s1);

	always_ff @(posedge clk) begin
		num_s2 <= VW'(NUM_W'(rref_q) * NUM_W'(adc_s1));
		den_s2 <= VW'(DNM_W'(rnom_q) * DNM_W'(span[FS_W-1:0]));
	end

	// ---------------- log2 of both, 97 stages ----------------
	ntc_log2 #(.VW(VW)) u_log_num (.clk(clk), .v(num_s2), .r(lnum));
	ntc_log2 #(.VW(VW)) u_log_den (.clk(clk), .v(den_s2), .r(lden));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOG_LAT; i++) begin
				tag_d[i] <= '0;
			end
		end else begin
			tag_d[0] <= tag_s2;
			for (int i = 1; i < LOG_LAT; i++) begin
				tag_d[i] <= tag_d[i-1];
			end
		end
	end

	// ---------------- stage 3: log difference, sign and magnitude ----------------
	assign diff = {1'b0, lnum} - {1'b0, lden};

	always_ff @(posedge clk) begin
		neg_s3 <= diff[LOG_W];
		mag_s3 <= diff[LOG_W] ? LOG_W'(-diff) : diff[LOG_W-1:0];
	end

	// ---------------- stage 4: times ln2, partial products ----------------
	always_ff @(posedge clk) begin
		neg_s4  <= neg_s3;
		b0c0_s4 <= 64'(mag_s3[31:0]) * 64'(LN2_Q64[31:0]);
		b0c1_s4 <= 64'(mag_s3[31:0]) * 64'(LN2_Q64[63:32]);
		b1c0_s4 <= 54'(mag_s3[53:32]) * 54'(LN2_Q64[31:0]);
		b1c1_s4 <= 54'(mag_s3[53:32]) * 54'(LN2_Q64[63:32]);
	end

	// ---------------- stage 5: high word, round to q40 ----------------
	assign lsum = {b1c1_s4, 64'd0} + 118'({b0c1_s4, 32'd0}) +
	              118'({b1c0_s4, 32'd0}) + 118'(b0c0_s4);
	assign lnr  = {1'b0, lsum[117:64]} + 55'd128;

	always_ff @(posedge clk) begin
		neg_s5 <= neg_s4;
		ln_s5  <= lnr[LOG_W:8];
	end

	// ---------------- stage 6: tnom * ln ----------------
	always_ff @(posedge clk) begin
		neg_s6  <= neg_s5;
		prod_s6 <= 63'(tnom_q) * 63'(ln_s5);
	end

	// ---------------- stage 7: divisor d = 100*beta + tnom*ln ----------------
	assign dq = neg_s6 ? (66'(base_q) - 66'(prod_s6)) : (66'(base_q) + 66'(prod_s6));

	always_ff @(posedge clk) begin
		d_s7 <= dq[DEN_W-1:0];
		n_s7 <= NUMER_W'(p_q) << 40;
	end

	// control through the back end; a non-positive 1/T is too hot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
		end else begin
			tag_s3 <= tag_d[LOG_LAT-1];
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= '{valid: tag_s6.valid, fault: tag_s6.fault,
			            sat: dq[65] || (dq == '0)};
		end
	end

	// ---------------- 100*tnom*beta / d, round, format ----------------
	ntc_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.tag_in     (tag_s7),
		.d          (d_s7),
		.n          (n_s7),
		.out_valid  (result_valid),
		.out_temp   (temperature_centi_c),
		.out_status (st)
	);

	assign status = st;

	// ---------------- checks ----------------
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (st == ST_FAULT) |-> temperature_centi_c == '0)
		else $error("fault result with nonzero temperature");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (st == ST_SAT) |-> temperature_centi_c == $signed(TEMP_MAX))
		else $error("saturated result not at limit");

	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (st == ST_OK) |->
			(temperature_centi_c >= -18'sd27315) && (temperature_centi_c <= 18'sd100000))
		else $error("ok result out of range");

	a_fault_flows: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid && tag_s1.fault |=> tag_s2.valid && tag_s2.fault)
		else $error("fault flag lost in front end");

endmodule

// ===== hw/rtl/ntc_log2.sv =====
// ----------------------------------------------------------------------------
// ntc_log2
// pipelined log2 in q48, one squaring step per two stages
// ----------------------------------------------------------------------------
module ntc_log2 #(
	parameter int VW = 33
) (
	input  logic                  clk,
	input  logic [VW-1:0]         v,
	output logic [ntc_pkg::LOG_W-1:0] r
);
	import ntc_pkg::*;

	logic [5:0]       e;
	logic [62:0]      m_s  [0:LOG_FRAC];
	logic [LOG_W-1:0] r_s  [0:LOG_FRAC];
	logic [63:0]      p00_s [0:LOG_FRAC-1];
	logic [62:0]      p01_s [0:LOG_FRAC-1];
	logic [61:0]      p11_s [0:LOG_FRAC-1];
	logic [LOG_W-1:0] ra_s  [0:LOG_FRAC-1];

	// leading one position
	always_comb begin
		e = '0;
		for (int i = 0; i < VW; i++) begin
			if (v[i]) begin
				e = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		m_s[0] <= 63'(v) << (6'd62 - e);
		r_s[0] <= {e, {LOG_FRAC{1'b0}}};
	end

	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_step
		logic [125:0] sq;
		logic [63:0]  t;

		// partial products of the square
		always_ff @(posedge clk) begin
			p00_s[k] <= 64'(m_s[k][31:0]) * 64'(m_s[k][31:0]);
			p01_s[k] <= 63'(m_s[k][31:0]) * 63'(m_s[k][62:32]);
			p11_s[k] <= 62'(m_s[k][62:32]) * 62'(m_s[k][62:32]);
			ra_s[k]  <= r_s[k];
		end

		assign sq = {p11_s[k], 64'd0} + 126'({p01_s[k], 33'd0}) + 126'(p00_s[k]);
		assign t  = sq[125:62];

		always_ff @(posedge clk) begin
			m_s[k+1] <= t[63] ? t[63:1] : t[62:0];
			r_s[k+1] <= ra_s[k] | (LOG_W'(t[63]) << (LOG_FRAC - 1 - k));
		end
	end

	assign r = r_s[LOG_FRAC];

endmodule

// ===== hw/rtl/ntc_div.sv =====
// ----------------------------------------------------------------------------
// ntc_div
// restoring divider, one quotient bit per stage, rounding and output format
// ----------------------------------------------------------------------------
module ntc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ntc_pkg::ntc_tag_t             tag_in,
	input  logic [ntc_pkg::DEN_W-1:0]     d,
	input  logic [ntc_pkg::NUMER_W-1:0]   n,
	output logic                          out_valid,
	output logic signed [ntc_pkg::TEMP_W-1:0] out_temp,
	output ntc_pkg::status_t              out_status
);
	import ntc_pkg::*;

	ntc_tag_t         tag_s [0:Q_BITS];
	logic [REM_W-1:0] rem_s [0:Q_BITS];
	logic [Q_BITS-1:0] q_s  [0:Q_BITS];
	logic [DEN_W-1:0] d_s   [0:Q_BITS];

	logic              too_big;
	logic              up;
	logic [TEMP_W-1:0] q1;
	logic              sat_f;

	// quotient would not fit 17 bits: certainly saturated
	assign too_big = REM_W'(n) >= (REM_W'(d) << Q_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else begin
			tag_s[0] <= '{valid: tag_in.valid, fault: tag_in.fault,
			              sat: tag_in.sat | too_big};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= REM_W'(n);
		q_s[0]   <= '0;
		d_s[0]   <= d;
	end

	for (genvar k = 0; k < Q_BITS; k++) begin : g_bit
		logic [REM_W-1:0] dsh;
		logic             ge;

		assign dsh = REM_W'(d_s[k]) << (Q_BITS - 1 - k);
		assign ge  = rem_s[k] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? rem_s[k] - dsh : rem_s[k];
			q_s[k+1]   <= q_s[k] | (Q_BITS'(ge) << (Q_BITS - 1 - k));
			d_s[k+1]   <= d_s[k];
		end
	end

	// round half up
	assign up    = rem_s[Q_BITS] >= (REM_W'(d_s[Q_BITS]) - rem_s[Q_BITS]);
	assign q1    = TEMP_W'(q_s[Q_BITS]) + TEMP_W'(up);
	assign sat_f = tag_s[Q_BITS].sat || (q1 > Q_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= tag_s[Q_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s[Q_BITS].fault) begin
			out_temp   <= '0;
			out_status <= ST_FAULT;
		end else if (sat_f) begin
			out_temp   <= TEMP_MAX;
			out_status <= ST_SAT;
		end else begin
			out_temp   <= q1 - KELVIN_CENTI;
			out_status <= ST_OK;
		end
	end

endmodule
